// ----- hw/rtl/dkft_pkg.sv -----
// ----------------------------------------------------------------------------
// dkft_pkg
// Shared types and constants for the dual-key segment floor table.
// ----------------------------------------------------------------------------
package dkft_pkg;

    localparam int TABLE_DEPTH_DEF = 64;

    localparam int KEY_W       = 64;
    localparam int TAG_W       = 32;
    localparam int RANK_W      = 6;
    localparam int STATUS_W    = 3;
    localparam int COUNT_OUT_W = 7;
    localparam int KIND_W      = 2;
    localparam int S_TDATA_W   = 168;
    localparam int M_TDATA_W   = 176;

    typedef enum logic [KIND_W-1:0] {
        KIND_INSERT     = 2'd0,
        KIND_FIND_FRAME = 2'd1,
        KIND_FIND_TIME  = 2'd2,
        KIND_READ_RANK  = 2'd3
    } kind_t;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK         = 3'd0,
        ST_INCONS     = 3'd1,
        ST_TOO_SMALL  = 3'd2,
        ST_FULL       = 3'd3,
        ST_RANK_RANGE = 3'd4
    } status_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SCAN,
        S_DECIDE,
        S_SHIFT,
        S_WRITE,
        S_DONE
    } fsm_state_t;

    typedef struct packed {
        logic [TAG_W-1:0] tag;
        logic [KEY_W-1:0] time_stamp;
        logic [KEY_W-1:0] frame;
    } entry_t;

    localparam int ENTRY_W = $bits(entry_t);

    typedef struct packed {
        logic capture;
        logic scan;
        logic decide;
        logic shift;
        logic write_new;
        logic load_out;
    } cmd_t;

    typedef struct packed {
        logic scan_done;
        logic need_write;
        logic shift_done;
    } stat_t;

endpackage

// ----- hw/rtl/dkft_ram.sv -----
// ----------------------------------------------------------------------------
// dkft_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module dkft_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ----- hw/rtl/dkft_ctrl.sv -----
// ----------------------------------------------------------------------------
// dkft_ctrl
// Sequencer: scan, decide, shift, write and result hand-off.
// ----------------------------------------------------------------------------
module dkft_ctrl (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          s_axis_tvalid,
    output logic                          s_axis_tready,
    input  logic [dkft_pkg::KIND_W-1:0]   s_axis_tuser,
    output logic                          m_axis_tvalid,
    input  logic                          m_axis_tready,
    input  dkft_pkg::stat_t               stat,
    output dkft_pkg::cmd_t                cmd
);

    import dkft_pkg::*;

    fsm_state_t state_reg;
    fsm_state_t state_next;
    logic       out_valid_reg;
    logic       out_valid_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_comb
    begin
        state_next    = state_reg;
        cmd           = '0;
        s_axis_tready = 1'b0;
        unique case (state_reg)
            S_IDLE:
            begin
                s_axis_tready = 1'b1;
                if (s_axis_tvalid)
                begin
                    cmd.capture = 1'b1;
                    state_next  = (kind_t'(s_axis_tuser) == KIND_READ_RANK) ? S_DECIDE : S_SCAN;
                end
            end
            S_SCAN:
            begin
                cmd.scan = 1'b1;
                if (stat.scan_done)
                begin
                    state_next = S_DECIDE;
                end
            end
            S_DECIDE:
            begin
                cmd.decide = 1'b1;
                state_next = stat.need_write ? S_SHIFT : S_DONE;
            end
            S_SHIFT:
            begin
                cmd.shift = 1'b1;
                if (stat.shift_done)
                begin
                    state_next = S_WRITE;
                end
            end
            S_WRITE:
            begin
                cmd.write_new = 1'b1;
                state_next    = S_DONE;
            end
            S_DONE:
            begin
                if (!out_valid_reg || m_axis_tready)
                begin
                    cmd.load_out = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        if (cmd.load_out)
        begin
            out_valid_next = 1'b1;
        end
        else if (m_axis_tready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    assign m_axis_tvalid = out_valid_reg;

endmodule

// ----- hw/rtl/dkft_dp.sv -----
// ----------------------------------------------------------------------------
// dkft_dp
// Datapath: key registers, floor scan, insert shift, table RAM, result beat.
// ----------------------------------------------------------------------------
module dkft_dp #(
    parameter int TABLE_DEPTH = dkft_pkg::TABLE_DEPTH_DEF
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic [dkft_pkg::S_TDATA_W-1:0]   s_axis_tdata,
    input  logic [dkft_pkg::KIND_W-1:0]      s_axis_tuser,
    output logic [dkft_pkg::M_TDATA_W-1:0]   m_axis_tdata,
    input  dkft_pkg::cmd_t                   cmd,
    output dkft_pkg::stat_t                  stat
);

    import dkft_pkg::*;

    localparam int AW = $clog2(TABLE_DEPTH);
    localparam int CW = $clog2(TABLE_DEPTH + 1);

    kind_t               kind_reg;
    logic [KEY_W-1:0]    frame_reg;
    logic [KEY_W-1:0]    time_reg;
    logic [TAG_W-1:0]    tag_reg;
    logic [RANK_W-1:0]   rank_reg;
    logic [CW-1:0]       count_reg;
    logic [CW-1:0]       scan_ptr_reg;
    logic                cmp_v_reg;
    logic [CW-1:0]       cmp_idx_reg;
    logic [CW-1:0]       nf_reg;
    logic [CW-1:0]       nt_reg;
    entry_t              floor_f_reg;
    entry_t              floor_t_reg;
    status_t             status_reg;
    logic [CW-1:0]       sh_ptr_reg;
    logic                pend_reg;
    logic [AW-1:0]       dst_reg;
    logic [M_TDATA_W-1:0] out_data_reg;

    entry_t              rd_data;
    entry_t              new_entry;
    entry_t              wr_data;
    entry_t              out_entry;
    logic                we;
    logic [AW-1:0]       waddr;
    logic                re;
    logic [AW-1:0]       raddr;

    logic                scan_issue;
    logic                sh_more;
    logic                sh_issue;
    logic [CW-1:0]       sh_prev;
    logic                rank_ok;
    logic                rank_issue;
    logic [CW+RANK_W-1:0] rank_ext;
    logic [CW+RANK_W-1:0] count_rank_ext;
    logic [CW+COUNT_OUT_W-1:0] count_ext;
    logic                frame_le;
    logic                time_le;
    logic                frame_eq;
    logic                time_eq;
    status_t             dec_status;
    logic                ins_write;

    assign new_entry.frame      = frame_reg;
    assign new_entry.time_stamp = time_reg;
    assign new_entry.tag        = tag_reg;

    assign rank_ext       = {{CW{1'b0}}, rank_reg};
    assign count_rank_ext = {{RANK_W{1'b0}}, count_reg};
    assign count_ext      = {{COUNT_OUT_W{1'b0}}, count_reg};
    assign rank_ok        = rank_ext < count_rank_ext;

    assign scan_issue = cmd.scan && (scan_ptr_reg < count_reg);
    assign sh_more    = sh_ptr_reg > nf_reg;
    assign sh_issue   = cmd.shift && sh_more;
    assign sh_prev    = sh_ptr_reg - CW'(1);
    assign rank_issue = cmd.decide && (kind_reg == KIND_READ_RANK) && rank_ok;

    assign frame_le = rd_data.frame <= frame_reg;
    assign time_le  = $signed(rd_data.time_stamp) <= $signed(time_reg);

    assign frame_eq = floor_f_reg.frame == frame_reg;
    assign time_eq  = floor_f_reg.time_stamp == time_reg;

    always_comb
    begin
        ins_write = 1'b0;
        if (nf_reg != nt_reg)
        begin
            dec_status = ST_INCONS;
        end
        else if ((nf_reg != '0) && frame_eq && time_eq)
        begin
            dec_status = ST_OK;
        end
        else if ((nf_reg != '0) && (frame_eq || time_eq))
        begin
            dec_status = ST_INCONS;
        end
        else if (count_reg == CW'(TABLE_DEPTH))
        begin
            dec_status = ST_FULL;
        end
        else
        begin
            dec_status = ST_OK;
            ins_write  = 1'b1;
        end
        case (kind_reg)
            KIND_FIND_FRAME:
            begin
                ins_write  = 1'b0;
                dec_status = (nf_reg == '0) ? ST_TOO_SMALL : ST_OK;
            end
            KIND_FIND_TIME:
            begin
                ins_write  = 1'b0;
                dec_status = (nt_reg == '0) ? ST_TOO_SMALL : ST_OK;
            end
            KIND_READ_RANK:
            begin
                ins_write  = 1'b0;
                dec_status = rank_ok ? ST_OK : ST_RANK_RANGE;
            end
            default:
            begin
            end
        endcase
    end

    assign stat.scan_done  = (scan_ptr_reg >= count_reg) && !cmp_v_reg;
    assign stat.need_write = ins_write;
    assign stat.shift_done = !sh_more && !pend_reg;

    always_comb
    begin
        re    = scan_issue || sh_issue || rank_issue;
        raddr = scan_ptr_reg[AW-1:0];
        if (sh_issue)
        begin
            raddr = sh_prev[AW-1:0];
        end
        else if (rank_issue)
        begin
            raddr = rank_ext[AW-1:0];
        end
        we      = 1'b0;
        waddr   = dst_reg;
        wr_data = rd_data;
        if (cmd.shift && pend_reg)
        begin
            we = 1'b1;
        end
        else if (cmd.write_new)
        begin
            we      = 1'b1;
            waddr   = nf_reg[AW-1:0];
            wr_data = new_entry;
        end
    end

    dkft_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (TABLE_DEPTH)
    ) u_table (
        .clk   (clk),
        .we    (we),
        .waddr (waddr),
        .wdata (wr_data),
        .re    (re),
        .raddr (raddr),
        .rdata (rd_data)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg    <= '0;
            scan_ptr_reg <= '0;
            cmp_v_reg    <= 1'b0;
            pend_reg     <= 1'b0;
        end
        else
        begin
            if (cmd.capture)
            begin
                scan_ptr_reg <= '0;
                cmp_v_reg    <= 1'b0;
            end
            else
            begin
                if (scan_issue)
                begin
                    scan_ptr_reg <= scan_ptr_reg + CW'(1);
                end
                cmp_v_reg <= scan_issue;
            end
            if (cmd.decide)
            begin
                pend_reg <= 1'b0;
            end
            else if (cmd.shift)
            begin
                pend_reg <= sh_issue;
            end
            if (cmd.write_new)
            begin
                count_reg <= count_reg + CW'(1);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            kind_reg  <= kind_t'(s_axis_tuser);
            frame_reg <= s_axis_tdata[63:0];
            time_reg  <= s_axis_tdata[127:64];
            tag_reg   <= s_axis_tdata[159:128];
            rank_reg  <= s_axis_tdata[165:160];
            nf_reg    <= '0;
            nt_reg    <= '0;
        end
        else if (cmp_v_reg)
        begin
            if (frame_le)
            begin
                nf_reg      <= cmp_idx_reg + CW'(1);
                floor_f_reg <= rd_data;
            end
            if (time_le)
            begin
                nt_reg      <= cmp_idx_reg + CW'(1);
                floor_t_reg <= rd_data;
            end
        end
        if (scan_issue)
        begin
            cmp_idx_reg <= scan_ptr_reg;
        end
        if (cmd.decide)
        begin
            status_reg <= dec_status;
            sh_ptr_reg <= count_reg;
        end
        if (sh_issue)
        begin
            sh_ptr_reg <= sh_prev;
            dst_reg    <= sh_ptr_reg[AW-1:0];
        end
        if (cmd.load_out)
        begin
            out_data_reg <= {6'b0, count_ext[COUNT_OUT_W-1:0], out_entry.tag,
                             out_entry.time_stamp, out_entry.frame, status_reg};
        end
    end

    always_comb
    begin
        out_entry = '0;
        if (status_reg == ST_OK)
        begin
            case (kind_reg)
                KIND_FIND_FRAME: out_entry = floor_f_reg;
                KIND_FIND_TIME:  out_entry = floor_t_reg;
                KIND_READ_RANK:  out_entry = rd_data;
                default:         out_entry = '0;
            endcase
        end
    end

    assign m_axis_tdata = out_data_reg;

endmodule

// ----- hw/rtl/dual_key_segment_floor_table.sv -----
// ----------------------------------------------------------------------------
// dual_key_segment_floor_table
// Sorted segment table with floor lookup by frame number or by timestamp.
// ----------------------------------------------------------------------------
// One result beat per input beat. Finds and inserts scan the stored entries
// through the table RAM's single read port, one entry per cycle; an insert
// that is stored then shifts the later entries one RAM read/write per cycle.
// A new beat is taken while the previous result still waits in the output
// register.
module dual_key_segment_floor_table #(
    parameter int TABLE_DEPTH = dkft_pkg::TABLE_DEPTH_DEF
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             s_axis_tvalid,
    output logic                             s_axis_tready,
    // frame_id[63:0], time_stamp[127:64], value_tag[159:128], rank[165:160]
    input  logic [dkft_pkg::S_TDATA_W-1:0]   s_axis_tdata,
    // kind[1:0]
    input  logic [dkft_pkg::KIND_W-1:0]      s_axis_tuser,
    output logic                             m_axis_tvalid,
    input  logic                             m_axis_tready,
    // status[2:0], found_frame[66:3], found_time[130:67], found_tag[162:131],
    // entry_count[169:163]
    output logic [dkft_pkg::M_TDATA_W-1:0]   m_axis_tdata
);

    import dkft_pkg::*;

    cmd_t  cmd;
    stat_t stat;

    dkft_ctrl u_ctrl (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .stat          (stat),
        .cmd           (cmd)
    );

    dkft_dp #(
        .TABLE_DEPTH (TABLE_DEPTH)
    ) u_dp (
        .clk          (clk),
        .rst_n        (rst_n),
        .s_axis_tdata (s_axis_tdata),
        .s_axis_tuser (s_axis_tuser),
        .m_axis_tdata (m_axis_tdata),
        .cmd          (cmd),
        .stat         (stat)
    );

endmodule

// ----- tb/testbench.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench
// Stream-level check of the dual-key segment floor table.
// ----------------------------------------------------------------------------
// A directed table covers the empty table, key extremes, exact and half
// duplicates and floors that disagree. Random traffic follows: well-formed
// inserts into the gaps between stored entries, with finds and rank reads
// around stored keys. The run goes until the table is full and beyond. Each
// result beat is compared with its directed row's typed result or with a
// software copy of the table. Sender gaps and receiver stalls vary by phase.
// ----------------------------------------------------------------------------
module testbench;
    import dkft_pkg::*;

    localparam int          DEPTH         = TABLE_DEPTH_DEF;
    localparam int          RANDOM_ITEMS  = 850;
    localparam int          PHASE_ITEMS   = 100;
    localparam int          SETTLE_CYCLES = 2 * DEPTH + 16;
    localparam logic [63:0] KEY_MAX       = '1;
    localparam logic [63:0] SIGN_FLIP     = 64'h8000_0000_0000_0000;
    localparam logic signed [63:0] TIME_MIN = 64'sh8000_0000_0000_0000;
    localparam logic signed [63:0] TIME_MAX = 64'sh7FFF_FFFF_FFFF_FFFF;

    typedef struct {
        status_t             status;
        logic [63:0]         frame;
        logic signed [63:0]  tstamp;
        logic [31:0]         tag;
        logic [6:0]          count;
    } seg_result_t;

    typedef struct {
        kind_t               kind;
        logic [63:0]         frame;
        logic signed [63:0]  tstamp;
        logic [31:0]         tag;
        logic [5:0]          rank;
        bit                  typed;
        seg_result_t         result;
    } seg_item_t;

    logic                   clk = 1'b0;
    logic                   rst_n = 1'b0;
    logic                   s_axis_tvalid = 1'b0;
    logic                   s_axis_tready;
    // frame_id, time_stamp, value_tag, rank
    logic [S_TDATA_W-1:0]   s_axis_tdata = '0;
    // kind
    logic [KIND_W-1:0]      s_axis_tuser = '0;
    logic                   m_axis_tvalid;
    logic                   m_axis_tready = 1'b0;
    // status, found_frame, found_time, found_tag, entry_count
    logic [M_TDATA_W-1:0]   m_axis_tdata;

    // software copy of the table
    logic [63:0]            tbl_frame [DEPTH];
    logic signed [63:0]     tbl_time  [DEPTH];
    logic [31:0]            tbl_tag   [DEPTH];
    int                     tbl_count = 0;

    seg_result_t            pending [$];
    seg_item_t              directed [$];
    int                     mismatches = 0;
    int                     send_idle_pct = 0;
    int                     recv_stall_pct = 0;

    dual_key_segment_floor_table u_top (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    always #5 clk = ~clk;

    always @(negedge clk)
    begin
        m_axis_tready <= ($urandom_range(0, 99) >= recv_stall_pct);
    end

    function automatic logic [63:0] rand64();
        return {$urandom, $urandom};
    endfunction

    function automatic int frame_floor(logic [63:0] key);
        int n;
        n = 0;
        for (int i = 0; i < tbl_count; i++)
            if (tbl_frame[i] <= key)
                n = i + 1;
        return n;
    endfunction

    function automatic int time_floor(logic signed [63:0] key);
        int n;
        n = 0;
        for (int i = 0; i < tbl_count; i++)
            if (tbl_time[i] <= key)
                n = i + 1;
        return n;
    endfunction

    function automatic seg_result_t apply_item(seg_item_t it);
        seg_result_t r;
        int nf;
        int nt;
        r.status = ST_OK;
        r.frame  = '0;
        r.tstamp = '0;
        r.tag    = '0;
        nf = 0;
        case (it.kind)
            KIND_INSERT:
            begin
                nf = frame_floor(it.frame);
                nt = time_floor(it.tstamp);
                if (nf != nt)
                    r.status = ST_INCONS;
                else if (nf > 0 && tbl_frame[nf-1] == it.frame && tbl_time[nf-1] == it.tstamp)
                    r.status = ST_OK;
                else if (nf > 0 && (tbl_frame[nf-1] == it.frame || tbl_time[nf-1] == it.tstamp))
                    r.status = ST_INCONS;
                else if (tbl_count >= DEPTH)
                    r.status = ST_FULL;
                else
                begin
                    for (int i = tbl_count; i > nf; i--)
                    begin
                        tbl_frame[i] = tbl_frame[i-1];
                        tbl_time[i]  = tbl_time[i-1];
                        tbl_tag[i]   = tbl_tag[i-1];
                    end
                    tbl_frame[nf] = it.frame;
                    tbl_time[nf]  = it.tstamp;
                    tbl_tag[nf]   = it.tag;
                    tbl_count++;
                end
            end
            KIND_FIND_FRAME, KIND_FIND_TIME:
            begin
                nf = (it.kind == KIND_FIND_FRAME) ? frame_floor(it.frame) : time_floor(it.tstamp);
                if (nf == 0)
                    r.status = ST_TOO_SMALL;
                else
                begin
                    r.frame  = tbl_frame[nf-1];
                    r.tstamp = tbl_time[nf-1];
                    r.tag    = tbl_tag[nf-1];
                end
            end
            default:
            begin
                if (int'(it.rank) < tbl_count)
                begin
                    r.frame  = tbl_frame[it.rank];
                    r.tstamp = tbl_time[it.rank];
                    r.tag    = tbl_tag[it.rank];
                end
                else
                    r.status = ST_RANK_RANGE;
            end
        endcase
        r.count = 7'(tbl_count);
        return r;
    endfunction

    function automatic logic [63:0] pick_range(logic [63:0] lo, logic [63:0] hi);
        logic [63:0] span;
        span = hi - lo;
        case ($urandom_range(0, 7))
            0:       return lo;
            1:       return hi;
            default: return (span == KEY_MAX) ? rand64() : lo + rand64() % (span + 64'd1);
        endcase
    endfunction

    // keys that fit strictly between stored entries g-1 and g on both axes
    function automatic bit gap_keys(int g, output logic [63:0] f, output logic signed [63:0] t);
        logic [63:0] flo;
        logic [63:0] fhi;
        logic [63:0] tlo;
        logic [63:0] thi;
        flo = '0;
        fhi = KEY_MAX;
        tlo = '0;
        thi = KEY_MAX;
        f = '0;
        t = '0;
        if (g > 0)
        begin
            if (tbl_frame[g-1] == KEY_MAX || tbl_time[g-1] == TIME_MAX)
                return 0;
            flo = tbl_frame[g-1] + 64'd1;
            tlo = (tbl_time[g-1] ^ SIGN_FLIP) + 64'd1;
        end
        if (g < tbl_count)
        begin
            if (tbl_frame[g] == '0 || tbl_time[g] == TIME_MIN)
                return 0;
            fhi = tbl_frame[g] - 64'd1;
            thi = (tbl_time[g] ^ SIGN_FLIP) - 64'd1;
        end
        if (flo > fhi || tlo > thi)
            return 0;
        f = pick_range(flo, fhi);
        t = pick_range(tlo, thi) ^ SIGN_FLIP;
        return 1;
    endfunction

    // time keys handled in offset binary so one ordering serves both axes
    function automatic logic [63:0] probe_key(bit by_time);
        logic [63:0] flip;
        logic [63:0] base;
        logic [63:0] k;
        int i;
        flip = by_time ? SIGN_FLIP : '0;
        base = rand64();
        if (tbl_count > 0)
        begin
            i = $urandom_range(0, tbl_count - 1);
            base = by_time ? (tbl_time[i] ^ SIGN_FLIP) : tbl_frame[i];
        end
        case ($urandom_range(0, 6))
            0, 1: k = base;
            2:    k = base - 64'd1;
            3:    k = base + 64'd1;
            4:    k = $urandom_range(0, 1) ? KEY_MAX : '0;
            default: k = rand64();
        endcase
        return k ^ flip;
    endfunction

    task automatic random_item(output seg_item_t it);
        int sel;
        int g;
        int h;
        int i;
        bit ok;
        logic [63:0] f2;
        logic signed [63:0] t2;
        it.kind   = KIND_INSERT;
        it.frame  = rand64();
        it.tstamp = rand64();
        it.tag    = $urandom;
        it.rank   = 6'($urandom);
        it.typed  = 0;
        it.result.status = ST_OK;
        it.result.frame  = '0;
        it.result.tstamp = '0;
        it.result.tag    = '0;
        it.result.count  = '0;
        i = (tbl_count > 0) ? $urandom_range(0, tbl_count - 1) : 0;
        sel = $urandom_range(0, 99);
        if (sel < 18)
        begin
            ok = 0;
            for (int tries = 0; tries < 4 && !ok; tries++)
            begin
                g = $urandom_range(0, tbl_count);
                ok = gap_keys(g, f2, t2);
            end
            if (ok)
            begin
                it.frame  = f2;
                it.tstamp = t2;
            end
        end
        else if (sel < 28)
        begin
            if (tbl_count > 0)
                case ($urandom_range(0, 3))
                    0:
                    begin
                        it.frame  = tbl_frame[i];
                        it.tstamp = tbl_time[i];
                    end
                    1:
                    begin
                        it.frame  = tbl_frame[i];
                        it.tstamp = tbl_time[i] + $urandom_range(1, 3);
                    end
                    2:
                    begin
                        it.frame  = tbl_frame[i] + $urandom_range(1, 3);
                        it.tstamp = tbl_time[i];
                    end
                    default:
                    begin
                        g = $urandom_range(0, tbl_count);
                        h = (g + 1 + $urandom_range(0, tbl_count - 1)) % (tbl_count + 1);
                        if (gap_keys(g, f2, t2))
                            it.frame = f2;
                        if (gap_keys(h, f2, t2))
                            it.tstamp = t2;
                    end
                endcase
        end
        else if (sel < 52)
        begin
            it.kind  = KIND_FIND_FRAME;
            it.frame = probe_key(0);
        end
        else if (sel < 76)
        begin
            it.kind   = KIND_FIND_TIME;
            it.tstamp = probe_key(1);
        end
        else
        begin
            it.kind = KIND_READ_RANK;
            if ($urandom_range(0, 1) && tbl_count > 0)
                it.rank = 6'(i);
        end
    endtask

    task automatic add_row(kind_t k, logic [63:0] f, logic signed [63:0] t, logic [31:0] tag,
                           logic [5:0] rank, bit typed, status_t st, logic [63:0] ef,
                           logic signed [63:0] et, logic [31:0] etag, logic [6:0] ec);
        seg_item_t it;
        it.kind   = k;
        it.frame  = f;
        it.tstamp = t;
        it.tag    = tag;
        it.rank   = rank;
        it.typed  = typed;
        it.result.status = st;
        it.result.frame  = ef;
        it.result.tstamp = et;
        it.result.tag    = etag;
        it.result.count  = ec;
        directed.push_back(it);
    endtask

    task automatic run_item(seg_item_t it);
        seg_result_t r;
        @(negedge clk);
        while ($urandom_range(0, 99) < send_idle_pct)
        begin
            s_axis_tvalid <= 1'b0;
            @(negedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= it.kind;
        s_axis_tdata  <= {2'b00, it.rank, it.tag, it.tstamp, it.frame};
        @(posedge clk);
        while (!s_axis_tready)
            @(posedge clk);
        r = apply_item(it);
        pending.push_back(it.typed ? it.result : r);
    endtask

    always @(posedge clk)
    begin
        seg_result_t got;
        seg_result_t want;
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            got.status = status_t'(m_axis_tdata[2:0]);
            got.frame  = m_axis_tdata[66:3];
            got.tstamp = m_axis_tdata[130:67];
            got.tag    = m_axis_tdata[162:131];
            got.count  = m_axis_tdata[169:163];
            if (pending.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("%0t: result beat with nothing expected, status %0d", $realtime,
                             got.status);
            end
            else
            begin
                want = pending.pop_front();
                if (got.status !== want.status || got.frame !== want.frame ||
                    got.tstamp !== want.tstamp || got.tag !== want.tag ||
                    got.count !== want.count)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("%0t: mismatch exp/got status %0d/%0d frame %h/%h time %h/%h tag %h/%h count %0d/%0d",
                                 $realtime, want.status, got.status, want.frame, got.frame,
                                 want.tstamp, got.tstamp, want.tag, got.tag, want.count,
                                 got.count);
                end
            end
        end
    end

    initial
    begin
        seg_item_t it;
        // empty table
        add_row(KIND_FIND_FRAME, '0, '0, '0, '0, 1, ST_TOO_SMALL, '0, '0, '0, 7'd0);
        add_row(KIND_FIND_TIME, '0, TIME_MIN, '0, '0, 1, ST_TOO_SMALL, '0, '0, '0, 7'd0);
        add_row(KIND_READ_RANK, '0, '0, '0, 6'd0, 1, ST_RANK_RANGE, '0, '0, '0, 7'd0);
        add_row(KIND_READ_RANK, '0, '0, '0, 6'd63, 1, ST_RANK_RANGE, '0, '0, '0, 7'd0);
        // first entry, then finds around it
        add_row(KIND_INSERT, 64'd1000, -64'sd5000, 32'hFFFF_FFFF, '0, 1, ST_OK, '0, '0, '0, 7'd1);
        add_row(KIND_READ_RANK, '0, '0, '0, 6'd0, 1, ST_OK, 64'd1000, -64'sd5000, 32'hFFFF_FFFF,
                7'd1);
        add_row(KIND_FIND_FRAME, KEY_MAX, '0, '0, '0, 1, ST_OK, 64'd1000, -64'sd5000,
                32'hFFFF_FFFF, 7'd1);
        add_row(KIND_FIND_TIME, '0, TIME_MAX, '0, '0, 1, ST_OK, 64'd1000, -64'sd5000,
                32'hFFFF_FFFF, 7'd1);
        add_row(KIND_FIND_FRAME, 64'd999, '0, '0, '0, 1, ST_TOO_SMALL, '0, '0, '0, 7'd1);
        add_row(KIND_FIND_TIME, '0, -64'sd5001, '0, '0, 1, ST_TOO_SMALL, '0, '0, '0, 7'd1);
        // exact duplicate keeps the stored tag
        add_row(KIND_INSERT, 64'd1000, -64'sd5000, 32'h0, '0, 1, ST_OK, '0, '0, '0, 7'd1);
        add_row(KIND_READ_RANK, '0, '0, '0, 6'd0, 1, ST_OK, 64'd1000, -64'sd5000, 32'hFFFF_FFFF,
                7'd1);
        // half duplicates, then a fresh entry at the key maxima
        add_row(KIND_INSERT, 64'd1000, 64'sd7, 32'h1, '0, 1, ST_INCONS, '0, '0, '0, 7'd1);
        add_row(KIND_INSERT, 64'd2000, -64'sd5000, 32'h2, '0, 1, ST_INCONS, '0, '0, '0, 7'd1);
        add_row(KIND_INSERT, KEY_MAX, TIME_MAX, 32'h0, '0, 1, ST_OK, '0, '0, '0, 7'd2);
        // floors disagree
        add_row(KIND_INSERT, 64'd500, 64'sd0, 32'h3, '0, 1, ST_INCONS, '0, '0, '0, 7'd2);
        add_row(KIND_INSERT, 64'd2000, -64'sd6000, 32'h4, '0, 1, ST_INCONS, '0, '0, '0, 7'd2);
        add_row(KIND_INSERT, KEY_MAX - 64'd1, TIME_MAX, 32'h5, '0, 1, ST_INCONS, '0, '0, '0,
                7'd2);
        add_row(KIND_INSERT, 64'd3000, 64'sd0, 32'h5A5A_A5A5, '0, 1, ST_OK, '0, '0, '0, 7'd3);
        add_row(KIND_READ_RANK, '0, '0, '0, 6'd1, 0, ST_OK, '0, '0, '0, '0);
        add_row(KIND_READ_RANK, '0, '0, '0, 6'd2, 0, ST_OK, '0, '0, '0, '0);
        add_row(KIND_FIND_FRAME, 64'd2999, '0, '0, '0, 0, ST_OK, '0, '0, '0, '0);
        add_row(KIND_FIND_TIME, '0, -64'sd1, '0, '0, 0, ST_OK, '0, '0, '0, '0);

        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        foreach (directed[k])
            run_item(directed[k]);

        for (int n = 0; n < RANDOM_ITEMS; n++)
        begin
            if (n % PHASE_ITEMS == 0)
            begin
                // hold off until the block has answered everything
                @(negedge clk);
                s_axis_tvalid <= 1'b0;
                while (pending.size() > 0)
                    @(negedge clk);
                case ((n / PHASE_ITEMS) % 4)
                    0:       begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                    1:       begin send_idle_pct = 47; recv_stall_pct = 0;  end
                    2:       begin send_idle_pct = 0;  recv_stall_pct = 47; end
                    default: begin send_idle_pct = 30; recv_stall_pct = 30; end
                endcase
            end
            random_item(it);
            run_item(it);
        end

        @(negedge clk);
        s_axis_tvalid <= 1'b0;
        while (pending.size() > 0)
            @(negedge clk);
        repeat (SETTLE_CYCLES) @(negedge clk);
        if (mismatches == 0 && pending.size() == 0)
            $display("dual_key_segment_floor_table verification clean");
        else
            $display("dual_key_segment_floor_table verification failed");
        $finish;
    end

    initial
    begin
        #10_000_000;
        $display("dual_key_segment_floor_table verification failed");
        $finish;
    end

endmodule
